FILE: sv/adaptive_4bit_adpcm_encoder_defines.svh
// ----------------------------------------------------------------------------
// adaptive_4bit_adpcm_encoder_defines.svh
// Assertion macros for the ADPCM encoder.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_4BIT_ADPCM_ENCODER_DEFINES_SVH
`define ADAPTIVE_4BIT_ADPCM_ENCODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define A4E_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define A4E_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/adpcm4e_pkg.sv
// ----------------------------------------------------------------------------
// adpcm4e_pkg
// Shared types, constants and tables of the 4-bit ADPCM encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package adpcm4e_pkg;

  localparam int SIG_W  = 16;
  localparam int STEP_W = 15;
  localparam int DIVD_W = 20;
  localparam int SCL_W  = 10;
  localparam int PROD_W = STEP_W + SCL_W;

  localparam logic [STEP_W-1:0] STEP_MIN = 15'd127;
  localparam logic [STEP_W-1:0] STEP_MAX = 15'd24576;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic       sat;
    logic [3:0] quo;
  } div_status_t;

  function automatic logic [SCL_W-1:0] step_scale(input logic [2:0] mag);
    logic [SCL_W-1:0] s;
    unique case (mag)
      3'd4:    s = 10'h133;
      3'd5:    s = 10'h199;
      3'd6:    s = 10'h200;
      3'd7:    s = 10'h266;
      default: s = 10'h0e6;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: sv/adpcm4e_divider.sv
// ----------------------------------------------------------------------------
// adpcm4e_divider
// Restoring divider, one compare and subtract per cycle, quotient up to 15; a larger quotient is flagged as saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module adpcm4e_divider (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [adpcm4e_pkg::DIVD_W-1:0]   dividend_i,
  input  wire logic [adpcm4e_pkg::STEP_W-1:0]   divisor_i,
  output adpcm4e_pkg::div_status_t              status_o
);

  logic                             busy_q;
  logic                             done_q;
  logic                             sat_q;
  logic [3:0]                       quo_q;
  logic [2:0]                       cnt_q;
  logic [adpcm4e_pkg::DIVD_W-1:0]   rem_q;
  logic [adpcm4e_pkg::DIVD_W-1:0]   shifted;
  logic                             ge;

  assign shifted = {5'b0, divisor_i} << cnt_q;
  assign ge      = rem_q >= shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      quo_q  <= 4'd0;
      cnt_q  <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        sat_q  <= 1'b0;
        quo_q  <= 4'd0;
        cnt_q  <= 3'd4;
      end else if (busy_q) begin
        if (cnt_q == 3'd4) begin
          if (ge) begin
            sat_q  <= 1'b1;
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            cnt_q <= 3'd3;
          end
        end else begin
          if (ge) begin
            quo_q[cnt_q[1:0]] <= 1'b1;
          end
          if (cnt_q == 3'd0) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q - 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
    end else if (busy_q && cnt_q != 3'd4 && ge) begin
      rem_q <= rem_q - shifted;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign status_o.sat  = sat_q;
  assign status_o.quo  = quo_q;

endmodule

`default_nettype wire

FILE: sv/adaptive_4bit_adpcm_encoder.sv
// ----------------------------------------------------------------------------
// adaptive_4bit_adpcm_encoder
// Step-adaptive 4-bit ADPCM encoder packing two codes per byte.
// ----------------------------------------------------------------------------
// Each request carries one signed 16-bit sample. The wait from acceptance
// until the block can take the next request is shorter when the
// scaled difference reaches sixteen steps and the divider stops after its
// first compare; in_stall_o stays high meanwhile. The time is set by the
// restoring divider (up to five compare and subtract steps, one per clock)
// and two passes through the one 15x10 multiplier that serves both the
// prediction and the step update. Every second sample, and any sample
// flagged end_of_stream_i, yields one byte in an output register; the next
// request is taken while that byte waits, and the block only holds at the
// end of a request if the previous byte is still not taken.
// An end-of-stream sample resets prediction and step for a fresh stream.
`default_nettype none

module adaptive_4bit_adpcm_encoder (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [adpcm4e_pkg::SIG_W-1:0] sample_i,
  input  wire logic                                end_of_stream_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [7:0]                               code_byte_o,
  output logic                                     last_byte_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIFF = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_PRED = 3'd4;
  localparam logic [2:0] S_MUL2 = 3'd5;
  localparam logic [2:0] S_STEP = 3'd6;

  logic [2:0]                               state_q;
  logic signed [adpcm4e_pkg::SIG_W-1:0]     sample_q;
  logic                                     eos_q;
  logic signed [adpcm4e_pkg::SIG_W-1:0]     pred_q;
  logic [adpcm4e_pkg::STEP_W-1:0]           step_q;
  logic [3:0]                               pend_q;
  logic                                     half_q;
  logic                                     neg_q;
  logic [3:0]                               code_q;
  logic [adpcm4e_pkg::PROD_W-1:0]           prod_q;
  logic                                     out_valid_q;
  logic [7:0]                               code_byte_q;
  logic                                     last_byte_q;

  logic signed [16:0]                       diff;
  logic [16:0]                              diff_mag;
  logic [adpcm4e_pkg::DIVD_W-1:0]           dividend;
  adpcm4e_pkg::div_status_t                 div_st;
  logic                                     nz;
  logic [2:0]                               mag3;
  logic [adpcm4e_pkg::SCL_W-1:0]            mul_b;
  logic [adpcm4e_pkg::PROD_W-1:0]           prod_d;
  logic signed [17:0]                       pred_sum;
  logic signed [adpcm4e_pkg::SIG_W-1:0]     pred_d;
  logic [16:0]                              step_raw;
  logic [adpcm4e_pkg::STEP_W-1:0]           step_d;
  logic                                     out_block;
  logic                                     emit;

  assign diff     = {sample_q[15], sample_q} - {pred_q[15], pred_q};
  assign diff_mag = diff[16] ? 17'(-diff) : 17'(diff);
  assign dividend = {diff_mag, 3'b000};

  adpcm4e_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DIFF),
    .dividend_i (dividend),
    .divisor_i  (step_q),
    .status_o   (div_st)
  );

  assign nz   = div_st.sat | (div_st.quo != 4'd0);
  assign mag3 = div_st.sat ? 3'd7 : div_st.quo[3:1];

  assign mul_b  = (state_q == S_MUL1) ? {6'b0, code_q[2:0], 1'b1}
                                      : adpcm4e_pkg::step_scale(code_q[2:0]);
  assign prod_d = {10'b0, step_q} * {15'b0, mul_b};

  always_comb begin
    if (code_q[3]) begin
      pred_sum = {{2{pred_q[15]}}, pred_q} - {2'b00, prod_q[18:3]};
    end else begin
      pred_sum = {{2{pred_q[15]}}, pred_q} + {2'b00, prod_q[18:3]};
    end
    priority if (pred_sum < -18'sd32768) begin
      pred_d = 16'sh8000;
    end else if (pred_sum > 18'sd32767) begin
      pred_d = 16'sh7fff;
    end else begin
      pred_d = pred_sum[15:0];
    end
  end

  assign step_raw = prod_q[24:8];

  always_comb begin
    priority if (step_raw < {2'b00, adpcm4e_pkg::STEP_MIN}) begin
      step_d = adpcm4e_pkg::STEP_MIN;
    end else if (step_raw > {2'b00, adpcm4e_pkg::STEP_MAX}) begin
      step_d = adpcm4e_pkg::STEP_MAX;
    end else begin
      step_d = step_raw[14:0];
    end
  end

  assign out_block = out_valid_q && out_stall_i;
  assign emit      = half_q || eos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      eos_q       <= 1'b0;
      pred_q      <= '0;
      step_q      <= adpcm4e_pkg::STEP_MIN;
      pend_q      <= 4'd0;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_STEP && !out_block && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            eos_q   <= end_of_stream_i;
            state_q <= S_DIFF;
          end
        end
        S_DIFF: state_q <= S_DIV;
        S_DIV: begin
          if (div_st.done) begin
            state_q <= S_MUL1;
          end
        end
        S_MUL1: state_q <= S_PRED;
        S_PRED: begin
          pred_q  <= pred_d;
          state_q <= S_MUL2;
        end
        S_MUL2: state_q <= S_STEP;
        S_STEP: begin
          if (!out_block) begin
            state_q <= S_IDLE;
            if (eos_q) begin
              pred_q <= '0;
              step_q <= adpcm4e_pkg::STEP_MIN;
              pend_q <= 4'd0;
              half_q <= 1'b0;
            end else begin
              step_q <= step_d;
              half_q <= !half_q;
              pend_q <= half_q ? 4'd0 : code_q;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      sample_q <= sample_i;
    end
    if (state_q == S_DIFF) begin
      neg_q <= diff[16];
    end
    if (state_q == S_DIV && div_st.done) begin
      code_q <= {neg_q & nz, mag3};
    end
    if (state_q == S_MUL1 || state_q == S_MUL2) begin
      prod_q <= prod_d;
    end
    if (state_q == S_STEP && !out_block && emit) begin
      code_byte_q <= half_q ? {code_q, pend_q} : {4'b0000, code_q};
      last_byte_q <= eos_q;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign code_byte_o = code_byte_q;
  assign last_byte_o = last_byte_q;

`include "adaptive_4bit_adpcm_encoder_defines.svh"

  `A4E_ASSERT_SAME(a_step_range, 1'b1,
    (step_q >= adpcm4e_pkg::STEP_MIN) && (step_q <= adpcm4e_pkg::STEP_MAX),
    "step size out of range")
  `A4E_ASSERT_SAME(a_div_busy_state, div_st.busy, state_q == S_DIV,
    "divider busy outside divide state")
  `A4E_ASSERT_NEXT(a_eos_restart, (state_q == S_STEP) && eos_q && !out_block,
    (pred_q == 16'sd0) && (step_q == adpcm4e_pkg::STEP_MIN) && !half_q,
    "stream state not reset after final sample")
  `A4E_ASSERT_NEXT(a_no_overwrite, (state_q == S_STEP) && out_block,
    state_q == S_STEP, "pending byte overwritten")

endmodule

`default_nettype wire
